@@ rtl/core/diag_frame_reassembler_defines.svh @@
// ----------------------------------------------------------------------------
// Diagnostic frame reassembler assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DIAG_FRAME_REASSEMBLER_DEFINES_SVH
`define DIAG_FRAME_REASSEMBLER_DEFINES_SVH

// Checks that a condition holds in the same cycle as its antecedent.
`define DFR_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its antecedent.
`define DFR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Diagnostic frame reassembler package
// Sizes, register indexes and result status codes.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int HEADER_DW    = 4;
  localparam int MAX_FRAME_DW = 16384;

  localparam int FrameSizeW = 15;
  localparam int MaxPacketW = 11;
  localparam int CfgDataW   = 15;
  localparam int TagW       = 16;
  localparam int WordW      = 32;
  localparam int IdxW       = 14;
  localparam int FwW        = $clog2(MAX_FRAME_DW + 1);
  localparam int HdrIdxW    = (HEADER_DW > 1) ? $clog2(HEADER_DW) : 1;

  typedef enum logic [0:0] {
    CFG_FRAME_SIZE = 1'b0,
    CFG_MAX_PACKET = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DISCARDED = 3'd1,
    ST_GOOD      = 3'd2,
    ST_BAD       = 3'd3,
    ST_DISABLED  = 3'd4
  } status_e;

endpackage

@@ rtl/core/diag_frame_reassembler.sv @@
// ----------------------------------------------------------------------------
// Diagnostic frame reassembler
// Checks packet ids, forwards frame words with their index and flags each
// finished frame good or bad by comparing its header and footer words.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | content
//  ---------+---------------------------+------------------------------------
//  input    | in_valid_i / in_ready_o   | frame tag, packet tag, word, end
//  output   | out_valid_o / out_ready_i | status, index, word, frame id, end
//  config   | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// One beat is taken per cycle unless the output stalls, and its result is
// registered. The combinational id check and word count update set the rate.
// Reset clears all control state; the header store needs no clearing pass.
// A stalled output beat holds the input only while the output register is full.
// ----------------------------------------------------------------------------
`include "diag_frame_reassembler_defines.svh"

module diag_frame_reassembler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [dfr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dfr_pkg::TagW-1:0]    frame_tag_i,
  input  logic [dfr_pkg::TagW-1:0]    packet_tag_i,
  input  logic [dfr_pkg::WordW-1:0]   payload_word_i,
  input  logic                        packet_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic [dfr_pkg::IdxW-1:0]    word_index_o,
  output logic [dfr_pkg::WordW-1:0]   word_out_o,
  output logic [dfr_pkg::TagW-1:0]    frame_number_o,
  output logic                        frame_end_o
);
  import dfr_pkg::*;

  localparam logic [FwW-1:0] MaxFrame  = FwW'(MAX_FRAME_DW);
  localparam logic [FwW-1:0] HeaderLen = FwW'(HEADER_DW);

  logic [FrameSizeW-1:0] frame_size_q;
  logic [MaxPacketW-1:0] max_packet_q;
  logic                  attached_q, attached_d;
  logic [TagW-1:0]       cur_frame_q, cur_frame_d;
  logic [TagW-1:0]       next_packet_q, next_packet_d;
  logic [FwW-1:0]        frame_words_q, frame_words_d;
  logic [MaxPacketW-1:0] packet_words_q, packet_words_d;
  logic                  at_start_q, at_start_d;
  logic                  dropping_q, dropping_d;
  logic                  mismatch_q, mismatch_d;
  logic [WordW-1:0]      header_q [HEADER_DW];

  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [IdxW-1:0]       index_q, index_d;
  logic [WordW-1:0]      word_q, word_d;
  logic [TagW-1:0]       fnum_q, fnum_d;
  logic                  fend_q, fend_d;

  logic                  in_acc;
  logic [FwW-1:0]        eff_size;
  logic [MaxPacketW-1:0] max_pkt;
  logic [FwW-1:0]        footer_start;
  logic                  take;
  logic                  last_word;
  logic                  hdr_write;

  assign in_ready_o   = !out_valid_q || out_ready_i;
  assign in_acc       = in_valid_i && in_ready_o;
  assign eff_size     = (FwW'(frame_size_q) > MaxFrame) ? MaxFrame : FwW'(frame_size_q);
  assign max_pkt      = (max_packet_q == '0) ? MaxPacketW'(1) : max_packet_q;
  assign footer_start = (eff_size >= HeaderLen) ? eff_size - HeaderLen : '0;

  always_comb begin
    logic [FwW-1:0]     w;
    logic [FwW-1:0]     k;
    logic [WordW-1:0]   hdr_word;
    attached_d     = attached_q;
    cur_frame_d    = cur_frame_q;
    next_packet_d  = next_packet_q;
    frame_words_d  = frame_words_q;
    packet_words_d = packet_words_q;
    at_start_d     = at_start_q;
    dropping_d     = dropping_q;
    mismatch_d     = mismatch_q;
    status_d       = ST_DISCARDED;
    index_d        = '0;
    word_d         = '0;
    fnum_d         = '0;
    fend_d         = 1'b0;
    take           = 1'b0;
    last_word      = 1'b0;
    hdr_write      = 1'b0;
    w              = '0;
    k              = '0;
    hdr_word       = '0;

    if (eff_size == '0) begin
      attached_d     = 1'b0;
      at_start_d     = 1'b1;
      dropping_d     = 1'b0;
      packet_words_d = '0;
      status_d       = ST_DISABLED;
    end else begin
      if (at_start_q) begin
        packet_words_d = '0;
        dropping_d     = 1'b0;
        if (attached_q && frame_tag_i == cur_frame_q && packet_tag_i == next_packet_q) begin
          attached_d = 1'b1;
        end else if (packet_tag_i == '0) begin
          attached_d    = 1'b1;
          cur_frame_d   = frame_tag_i;
          next_packet_d = '0;
          frame_words_d = '0;
          mismatch_d    = 1'b0;
        end else begin
          attached_d = 1'b0;
          dropping_d = 1'b1;
        end
      end

      take = attached_d && !dropping_d && (packet_words_d < max_pkt)
             && (frame_words_d < eff_size);
      if (take) begin
        w         = frame_words_d;
        hdr_write = (w < HeaderLen);
        if (w >= footer_start) begin
          k        = w - footer_start;
          hdr_word = (k == w) ? payload_word_i : header_q[k[HdrIdxW-1:0]];
          if (k < HeaderLen && hdr_word != payload_word_i) begin
            mismatch_d = 1'b1;
          end
        end
        frame_words_d  = w + FwW'(1);
        packet_words_d = packet_words_d + MaxPacketW'(1);
        status_d       = ST_ACCEPTED;
        index_d        = w[IdxW-1:0];
        word_d         = payload_word_i;
        fnum_d         = cur_frame_d;
        if (frame_words_d == eff_size) begin
          last_word  = 1'b1;
          status_d   = mismatch_d ? ST_BAD : ST_GOOD;
          fend_d     = 1'b1;
          attached_d = 1'b0;
          if (!packet_end_i) begin
            dropping_d = 1'b1;
          end
        end
      end

      if (packet_end_i) begin
        if (attached_d && !dropping_d) begin
          next_packet_d = next_packet_d + TagW'(1);
        end
        at_start_d = 1'b1;
        dropping_d = 1'b0;
      end else begin
        at_start_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q   <= '0;
      max_packet_q   <= MaxPacketW'(256);
      attached_q     <= 1'b0;
      cur_frame_q    <= '0;
      next_packet_q  <= '0;
      frame_words_q  <= '0;
      packet_words_q <= '0;
      at_start_q     <= 1'b1;
      dropping_q     <= 1'b0;
      mismatch_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_FRAME_SIZE: begin
            frame_size_q   <= cfg_wdata_i[FrameSizeW-1:0];
            attached_q     <= 1'b0;
            at_start_q     <= 1'b1;
            dropping_q     <= 1'b0;
            packet_words_q <= '0;
          end
          CFG_MAX_PACKET: begin
            max_packet_q <= cfg_wdata_i[MaxPacketW-1:0];
          end
          default: begin
            max_packet_q <= max_packet_q;
          end
        endcase
      end else if (in_acc) begin
        attached_q     <= attached_d;
        cur_frame_q    <= cur_frame_d;
        next_packet_q  <= next_packet_d;
        frame_words_q  <= frame_words_d;
        packet_words_q <= packet_words_d;
        at_start_q     <= at_start_d;
        dropping_q     <= dropping_d;
        mismatch_q     <= mismatch_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      index_q  <= index_d;
      word_q   <= word_d;
      fnum_q   <= fnum_d;
      fend_q   <= fend_d;
      if (hdr_write) begin
        header_q[index_d[HdrIdxW-1:0]] <= payload_word_i;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign word_index_o   = index_q;
  assign word_out_o     = word_q;
  assign frame_number_o = fnum_q;
  assign frame_end_o    = fend_q;

  `DFR_ASSERT_SAME(a_attached_in_range, attached_q, frame_words_q < eff_size, "Attached frame has run past its length.")
  `DFR_ASSERT_NEXT(a_disabled_status, in_acc && !cfg_we_i && eff_size == '0, out_valid_q && status_q == ST_DISABLED, "Disabled block did not answer disabled.")
  `DFR_ASSERT_NEXT(a_detach_on_end, in_acc && !cfg_we_i && last_word, !attached_q && frame_words_q == eff_size, "Frame stayed attached after its final word.")
  `DFR_ASSERT_SAME(a_end_status, out_valid_q && frame_end_o, status_q == ST_GOOD || status_q == ST_BAD, "Frame end without a frame verdict.")

endmodule

@@ tb/sv/dfr_frame_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Diagnostic frame reassembler result checker
// Watches the register port and both beat channels. It keeps its own copy of
// the id check, the word count and the header and footer comparison, works out
// the result of every accepted input beat and compares each output beat field
// by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dfr_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [dfr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [dfr_pkg::TagW-1:0]     frame_tag_i,
  input  logic [dfr_pkg::TagW-1:0]     packet_tag_i,
  input  logic [dfr_pkg::WordW-1:0]    payload_word_i,
  input  logic                         packet_end_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [2:0]                   status_i,
  input  logic [dfr_pkg::IdxW-1:0]     word_index_i,
  input  logic [dfr_pkg::WordW-1:0]    word_out_i,
  input  logic [dfr_pkg::TagW-1:0]     frame_number_i,
  input  logic                         frame_end_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           good_o,
  output int                           bad_o
);
  import dfr_pkg::*;

  typedef struct packed {
    status_e             status;
    logic [IdxW-1:0]     idx;
    logic [WordW-1:0]    word;
    logic [TagW-1:0]     fnum;
    logic                fend;
  } frame_result_t;

  logic [FrameSizeW-1:0] size_reg;
  logic [MaxPacketW-1:0] maxpk_reg;
  bit                    attached;
  logic [TagW-1:0]       cur_frame;
  logic [TagW-1:0]       next_pkt;
  int unsigned           frame_words;
  int unsigned           pkt_words;
  bit                    at_start;
  bit                    dropping;
  bit                    footer_bad;
  logic [WordW-1:0]      hdr [HEADER_DW];

  frame_result_t         predicted [$];
  frame_result_t         due;

  function automatic void rewind();
    attached  = 1'b0;
    at_start  = 1'b1;
    dropping  = 1'b0;
    pkt_words = 0;
  endfunction

  function automatic frame_result_t reassemble(logic [TagW-1:0] ftag, logic [TagW-1:0] ptag,
                                               logic [WordW-1:0] word, logic pend);
    frame_result_t r;
    int unsigned   eff;
    int unsigned   mpk;
    int unsigned   fstart;
    int unsigned   w;
    r        = '0;
    r.status = ST_DISCARDED;
    eff      = (size_reg > MAX_FRAME_DW) ? MAX_FRAME_DW : size_reg;
    mpk      = (maxpk_reg == '0) ? 1 : maxpk_reg;
    if (eff == 0) begin
      rewind();
      r.status = ST_DISABLED;
      return r;
    end
    if (at_start) begin
      pkt_words = 0;
      dropping  = 1'b0;
      if (!(attached && ftag == cur_frame && ptag == next_pkt)) begin
        if (ptag == '0) begin
          attached    = 1'b1;
          cur_frame   = ftag;
          next_pkt    = '0;
          frame_words = 0;
          footer_bad  = 1'b0;
        end else begin
          attached = 1'b0;
          dropping = 1'b1;
        end
      end
    end
    if (attached && !dropping && pkt_words < mpk && frame_words < eff) begin
      w      = frame_words;
      fstart = (eff >= HEADER_DW) ? eff - HEADER_DW : 0;
      if (w < HEADER_DW) hdr[w] = word;
      if (w >= fstart && (w - fstart) < HEADER_DW && hdr[w - fstart] != word) footer_bad = 1'b1;
      frame_words = w + 1;
      pkt_words++;
      r.status = ST_ACCEPTED;
      r.idx    = w[IdxW-1:0];
      r.word   = word;
      r.fnum   = cur_frame;
      if (frame_words == eff) begin
        r.status = footer_bad ? ST_BAD : ST_GOOD;
        r.fend   = 1'b1;
        attached = 1'b0;
        if (!pend) dropping = 1'b1;
      end
    end
    if (pend) begin
      if (attached && !dropping) next_pkt = next_pkt + 1'b1;
      at_start = 1'b1;
      dropping = 1'b0;
    end else begin
      at_start = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    fail_count_o++;
    if (fail_count_o <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_reg    = '0;
      maxpk_reg   = MaxPacketW'(256);
      cur_frame   = '0;
      next_pkt    = '0;
      frame_words = 0;
      footer_bad  = 1'b0;
      for (int i = 0; i < HEADER_DW; i++) hdr[i] = '0;
      rewind();
      predicted.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FRAME_SIZE) begin
          size_reg = cfg_wdata_i[FrameSizeW-1:0];
          rewind();
        end else begin
          maxpk_reg = cfg_wdata_i[MaxPacketW-1:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding, status %0d", status_i));
        end else begin
          due = predicted.pop_front();
          if (status_i !== due.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i, due.status));
          if (word_index_i !== due.idx)
            report_mismatch($sformatf("word index %0d, expected %0d", word_index_i, due.idx));
          if (word_out_i !== due.word)
            report_mismatch($sformatf("word %h, expected %h", word_out_i, due.word));
          if (frame_number_i !== due.fnum)
            report_mismatch($sformatf("frame %h, expected %h", frame_number_i, due.fnum));
          if (frame_end_i !== due.fend)
            report_mismatch($sformatf("frame end %b, expected %b", frame_end_i, due.fend));
          checked_o++;
          if (due.status == ST_GOOD) good_o++;
          if (due.status == ST_BAD) bad_o++;
        end
      end
      if (in_valid_i && in_ready_i)
        predicted.push_back(reassemble(frame_tag_i, packet_tag_i, payload_word_i, packet_end_i));
      pending_o = predicted.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Diagnostic frame reassembler testbench
// Drives tagged packet beats and register writes with random idle gaps on the
// input and random stalls on the output. A short directed part is followed by
// well-formed frames with random content mixed with broken packets and noise.
// The checker predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
  import dfr_pkg::*;

  localparam int RandomBeats = 750;
  localparam int StallLimit  = 400;

  logic                clk         = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we      = 1'b0;
  logic                cfg_index   = 1'b0;
  logic [CfgDataW-1:0] cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic [TagW-1:0]     frame_tag   = '0;
  logic [TagW-1:0]     packet_tag  = '0;
  logic [WordW-1:0]    payload     = '0;
  logic                packet_end  = 1'b0;
  logic                out_ready   = 1'b0;

  logic                in_ready;
  logic                out_valid;
  logic [2:0]          status;
  logic [IdxW-1:0]     word_index;
  logic [WordW-1:0]    word_out;
  logic [TagW-1:0]     frame_number;
  logic                frame_end;

  int                  fail_count;
  int                  pending;
  int                  checked;
  int                  good;
  int                  bad;

  int unsigned         cfg_size    = 0;
  int unsigned         cfg_maxpk   = 256;
  int                  beats_sent  = 0;
  int                  cfg_writes  = 0;
  int                  idle_cycles = 0;

  always #5 clk = ~clk;

  diag_frame_reassembler dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .frame_tag_i   (frame_tag),
    .packet_tag_i  (packet_tag),
    .payload_word_i(payload),
    .packet_end_i  (packet_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .word_index_o  (word_index),
    .word_out_o    (word_out),
    .frame_number_o(frame_number),
    .frame_end_o   (frame_end)
  );

  dfr_frame_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .frame_tag_i   (frame_tag),
    .packet_tag_i  (packet_tag),
    .payload_word_i(payload),
    .packet_end_i  (packet_end),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .word_index_i  (word_index),
    .word_out_i    (word_out),
    .frame_number_i(frame_number),
    .frame_end_i   (frame_end),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .good_o        (good),
    .bad_o         (bad)
  );

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Timeout: no beat moved for %0d cycles.", StallLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_beat(logic [TagW-1:0] ft, logic [TagW-1:0] pt, logic [WordW-1:0] wd,
                           logic pe);
    int unsigned gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_tag  <= ft;
    packet_tag <= pt;
    payload    <= wd;
    packet_end <= pe;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_index_e idx, int unsigned val);
    cfg_index <= idx;
    cfg_wdata <= val[CfgDataW-1:0];
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_FRAME_SIZE) cfg_size = val;
    else cfg_maxpk = val[MaxPacketW-1:0];
    cfg_writes++;
  endtask

  task automatic send_noise(int unsigned n);
    for (int i = 0; i < n; i++)
      send_beat(TagW'($urandom), ($urandom_range(0, 3) == 0) ? '0 : TagW'($urandom), $urandom,
                $urandom_range(0, 1) == 1);
  endtask

  // Sends one frame as packets of the current size. A messy frame mixes in short,
  // overlong and broken packets and may stop early.
  task automatic send_frame(logic [TagW-1:0] ft, bit good_frame, bit messy,
                            int unsigned stop_after);
    int unsigned      eff;
    int unsigned      mpk;
    int unsigned      fstart;
    int unsigned      w;
    int unsigned      pid;
    int unsigned      len;
    int unsigned      sent;
    int unsigned      k;
    int unsigned      r;
    int               bad_k;
    bit               corrupt;
    logic [WordW-1:0] wd;
    logic [TagW-1:0]  ft_p;
    logic [TagW-1:0]  pt_p;
    logic [WordW-1:0] hdr_s [HEADER_DW];
    eff    = (cfg_size > MAX_FRAME_DW) ? MAX_FRAME_DW : cfg_size;
    mpk    = (cfg_maxpk == 0) ? 1 : cfg_maxpk;
    fstart = (eff >= HEADER_DW) ? eff - HEADER_DW : 0;
    bad_k  = good_frame ? -1 : int'($urandom_range(0, HEADER_DW - 1));
    w      = 0;
    pid    = 0;
    sent   = 0;
    while (w < eff) begin
      len     = mpk;
      ft_p    = ft;
      pt_p    = pid[TagW-1:0];
      corrupt = 1'b0;
      if (messy) begin
        r = $urandom_range(0, 9);
        case (r)
          0, 1: len = $urandom_range(1, mpk);
          2: len = mpk + $urandom_range(1, 3);
          3: begin
            corrupt = 1'b1;
            len     = $urandom_range(1, 3);
            if ($urandom_range(0, 1) == 0) ft_p = ft ^ (TagW'(1) << $urandom_range(0, TagW - 1));
            else pt_p = TagW'(pid + $urandom_range(1, 300));
          end
          4: return;
          5: len = (eff - w) + $urandom_range(1, 3);
          default: ;
        endcase
      end
      for (int i = 0; i < len; i++) begin
        if (!corrupt && i < mpk && w < eff) begin
          if (fstart > 0 && w >= fstart) begin
            k  = w - fstart;
            wd = hdr_s[k];
            if (int'(k) == bad_k) wd = wd ^ (WordW'(1) << $urandom_range(0, WordW - 1));
          end else begin
            wd = $urandom;
          end
          if (w < HEADER_DW) hdr_s[w] = wd;
          w++;
        end else begin
          wd = $urandom;
        end
        send_beat(ft_p, pt_p, wd, i == len - 1);
        sent++;
        if (stop_after != 0 && sent >= stop_after) return;
      end
      if (corrupt) return;
      pid++;
    end
  endtask

  task automatic pick_setting();
    int unsigned sz;
    int unsigned mp;
    drain();
    case ($urandom_range(0, 11))
      0: sz = 0;
      1: sz = MAX_FRAME_DW;
      2: sz = $urandom_range(MAX_FRAME_DW + 1, 32767);
      3: sz = $urandom_range(1, HEADER_DW);
      default: sz = $urandom_range(HEADER_DW + 1, 40);
    endcase
    case ($urandom_range(0, 9))
      0: mp = 0;
      1: mp = 1024;
      2: mp = 2047;
      3: mp = $urandom_range(13, 2047);
      default: mp = $urandom_range(1, 12);
    endcase
    if ($urandom_range(0, 3) != 0) write_cfg(CFG_FRAME_SIZE, sz);
    write_cfg(CFG_MAX_PACKET, mp);
  endtask

  initial begin
    int unsigned     eff_now;
    int unsigned     r;
    int              stop_at;
    logic [TagW-1:0] tag;
    logic [TagW-1:0] last_tag;
    last_tag = '0;
    repeat (7) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    send_beat(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_beat(16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
    drain();
    write_cfg(CFG_FRAME_SIZE, 6);
    write_cfg(CFG_MAX_PACKET, 3);
    send_frame(16'hA5A5, 1'b1, 1'b0, 0);
    send_frame(16'h5A5A, 1'b0, 1'b0, 0);
    send_beat(16'h1234, 16'h0007, 32'h0BAD_0BAD, 1'b0);
    send_beat(16'h1234, 16'h0007, 32'h0BAD_0BAD, 1'b1);
    send_beat(16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    send_beat(16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
    send_beat(16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    send_beat(16'h0000, 16'h0000, 32'h0000_0000, 1'b1);
    drain();
    write_cfg(CFG_MAX_PACKET, 0);
    send_beat(16'h0000, 16'h0001, 32'h0000_0001, 1'b1);
    send_beat(16'h0000, 16'h0002, 32'h0000_0002, 1'b0);
    send_beat(16'h0000, 16'h0002, 32'h0000_0003, 1'b1);
    send_beat(16'h0000, 16'h0003, 32'hFFFF_FFFF, 1'b1);
    send_beat(16'h8001, 16'h0000, 32'h8000_0001, 1'b1);

    stop_at = beats_sent + RandomBeats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) pick_setting();
      tag      = ($urandom_range(0, 4) == 0) ? last_tag : TagW'($urandom);
      last_tag = tag;
      eff_now  = (cfg_size > MAX_FRAME_DW) ? MAX_FRAME_DW : cfg_size;
      if (eff_now == 0) begin
        send_noise($urandom_range(1, 8));
      end else if (eff_now > 64) begin
        send_frame(tag, 1'b1, $urandom_range(0, 1) == 1, $urandom_range(1, 24));
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) send_noise($urandom_range(1, 6));
        else send_frame(tag, $urandom_range(0, 3) != 0, r <= 3, 0);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    $display("Sent %0d input beats across %0d register writes.", beats_sent, cfg_writes);
    $display("Checked %0d result beats; %0d frames closed good and %0d closed bad.",
             checked, good, bad);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
